FILE: rtl/mmd_pkg.sv
// ----------------------------------------------------------------------------
// mmd_pkg
// Shared widths and the sequencer state type of the moving mean difference.
// ----------------------------------------------------------------------------
package mmd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RESULT_W = 17;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_FINISH
    } t_state;

endpackage

FILE: rtl/mmd_sample_if.sv
// ----------------------------------------------------------------------------
// mmd_sample_if
// Valid/ready channel carrying one raw sensor sample per beat.
// ----------------------------------------------------------------------------
interface mmd_sample_if;

    logic                         valid;
    logic                         ready;
    logic [mmd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

FILE: rtl/mmd_result_if.sv
// ----------------------------------------------------------------------------
// mmd_result_if
// Valid/ready channel carrying one signed mean-minus-sample result per beat.
// ----------------------------------------------------------------------------
interface mmd_result_if;

    logic                                valid;
    logic                                ready;
    logic signed [mmd_pkg::RESULT_W-1:0] mean_minus_sample;

    modport source (output valid, output mean_minus_sample, input ready);
    modport sink   (input valid, input mean_minus_sample, output ready);

endinterface

FILE: rtl/mmd_ram.sv
// ----------------------------------------------------------------------------
// mmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 15
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/moving_mean_difference.sv
// ----------------------------------------------------------------------------
// moving_mean_difference
// Moving-average DC removal: window mean minus current sample.
// ----------------------------------------------------------------------------
// Each accepted sample replaces the oldest of the last WINDOW samples held in
// a small RAM, the running sum is corrected by the evicted entry, and the sum
// is divided (truncating) by the number of samples seen so far, saturating at
// WINDOW. The result is that mean minus the sample, 17-bit two's complement.
// Each sample passes, ready to ready, through the idle/accept state, the read
// state for the RAM read and sum update, the restoring divider that yields one
// quotient bit per cycle for the SUM_W = 16 + clog2(WINDOW) bits of the sum,
// and the finish state that forms the difference into the output register.
// Input ready is high only in idle; a result waiting in the output register
// does not block acceptance of the next sample, but holds that sample's result
// in the finish state until the waiting one is taken. No clearing pass is needed
// after reset: until the window has filled, the entry under the write pointer
// has never been written, and its read data is not subtracted from the sum.
// ----------------------------------------------------------------------------
module moving_mean_difference #(
    parameter int WINDOW = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mmd_sample_if.sink          i_sample,
    mmd_result_if.source        o_result
);

    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = mmd_pkg::SAMPLE_W + $clog2(WINDOW);
    localparam int DIVC_W = $clog2(SUM_W + 1);

    // sequencer
    mmd_pkg::t_state r_state, n_state;

    // datapath registers
    logic [mmd_pkg::SAMPLE_W-1:0]        r_sample;
    logic [PTR_W-1:0]                    r_wptr, n_wptr;
    logic [CNT_W-1:0]                    r_fill, n_fill;
    logic [SUM_W-1:0]                    r_sum, n_sum;
    logic [SUM_W-1:0]                    r_quo, n_quo;   // dividend in, quotient out
    logic [CNT_W-1:0]                    r_rem, n_rem;
    logic [DIVC_W-1:0]                   r_divc, n_divc;
    logic                                r_out_valid, n_out_valid;
    logic signed [mmd_pkg::RESULT_W-1:0] r_out_data, n_out_data;

    // control decoded from state
    logic accept;
    logic sample_ready;
    logic ram_we;
    logic load_out;

    // datapath intermediates
    logic [mmd_pkg::SAMPLE_W-1:0] ram_rdata;
    logic                         full;
    logic [SUM_W-1:0]             evicted;
    logic [CNT_W:0]               trial;
    logic                         fits;

    mmd_ram #(
        .WIDTH (mmd_pkg::SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (r_sample),
        .i_raddr (r_wptr),
        .o_rdata (ram_rdata)
    );

    assign accept = i_sample.valid && sample_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mmd_pkg::ST_IDLE: begin
                if (i_sample.valid) begin
                    n_state = mmd_pkg::ST_READ;
                end
            end
            mmd_pkg::ST_READ: begin
                n_state = mmd_pkg::ST_DIV;
            end
            mmd_pkg::ST_DIV: begin
                if (r_divc == DIVC_W'(1)) begin
                    n_state = mmd_pkg::ST_FINISH;
                end
            end
            mmd_pkg::ST_FINISH: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = mmd_pkg::ST_IDLE;
                end
            end
            default: n_state = mmd_pkg::ST_IDLE;
        endcase
    end

    // state-decoded controls
    always_comb begin
        sample_ready = 1'b0;
        ram_we       = 1'b0;
        load_out     = 1'b0;
        unique case (r_state)
            mmd_pkg::ST_IDLE:   sample_ready = 1'b1;
            mmd_pkg::ST_READ:   ram_we       = 1'b1;
            mmd_pkg::ST_DIV:    ;
            mmd_pkg::ST_FINISH: load_out     = !r_out_valid || o_result.ready;
            default:            ;
        endcase
    end

    assign i_sample.ready             = sample_ready;
    assign o_result.valid             = r_out_valid;
    assign o_result.mean_minus_sample = r_out_data;

    // the entry under the pointer holds a real sample only once the ring is full
    assign full    = (r_fill == CNT_W'(WINDOW));
    assign evicted = full ? SUM_W'(ram_rdata) : '0;

    // one restoring-divide step
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign fits  = (trial >= {1'b0, r_fill});

    always_comb begin
        n_wptr      = r_wptr;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_divc      = r_divc;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mmd_pkg::ST_READ: begin
                n_sum  = r_sum - evicted + SUM_W'(r_sample);
                n_quo  = n_sum;
                n_rem  = '0;
                n_divc = DIVC_W'(SUM_W);
                n_wptr = (r_wptr == PTR_W'(WINDOW - 1)) ? '0 : r_wptr + PTR_W'(1);
                if (!full) begin
                    n_fill = r_fill + CNT_W'(1);
                end
            end
            mmd_pkg::ST_DIV: begin
                n_quo  = {r_quo[SUM_W-2:0], fits};
                n_rem  = fits ? CNT_W'(trial - {1'b0, r_fill}) : trial[CNT_W-1:0];
                n_divc = r_divc - DIVC_W'(1);
            end
            mmd_pkg::ST_FINISH: begin
                if (load_out) begin
                    // mean never exceeds the largest sample, so 16 quotient bits suffice
                    n_out_valid = 1'b1;
                    n_out_data  = $signed({1'b0, r_quo[mmd_pkg::SAMPLE_W-1:0]})
                                - $signed({1'b0, r_sample});
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmd_pkg::ST_IDLE;
            r_wptr      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample.sample;
        end
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_divc     <= n_divc;
        r_out_data <= n_out_data;
    end

    // checks
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wptr <= PTR_W'(WINDOW - 1))
        else $error("write pointer beyond window");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SUM_W + CNT_W)'(r_sum) <= (SUM_W + CNT_W)'(r_fill) * (SUM_W + CNT_W)'(16'hFFFF))
        else $error("running sum exceeds what the filled window can hold");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmd_pkg::ST_DIV) |-> (r_fill != '0) && (r_rem < r_fill))
        else $error("divider remainder not below divisor");

    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == mmd_pkg::ST_READ) && (r_fill == $past(r_fill)))
        else $error("accepted beat did not start the read step");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmd_pkg::ST_READ) && (r_fill != CNT_W'(WINDOW))
        |=> r_fill == $past(r_fill) + CNT_W'(1))
        else $error("fill count did not advance while window filling");

endmodule
